@@ src/lfsp_pkg.sv @@
// Shared types and constants for the line-follow steering PID core.
// No dependencies; used by the top level, front and back of the core.
package lfsp_pkg;

  localparam int CFG_INDEX_WIDTH = 3;
  localparam int CFG_DATA_WIDTH  = 20;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_SERVO_CENTER         = 3'd0,
    REG_DERIVATIVE_GAIN      = 3'd1,
    REG_INTEGRAL_GAIN        = 3'd2,
    REG_UNCERTAINTY_LIMIT    = 3'd3,
    REG_FRAMES_BEFORE_FINISH = 3'd4
  } reg_e;

  localparam logic [15:0] SERVO_CENTER_RST = 16'd1500;
  localparam logic [7:0]  UNC_LIMIT_RST    = 8'd20;
  localparam logic [19:0] FRAMES_RST       = 20'd3000;

  localparam logic [6:0] POS_CENTER  = 7'd64;
  localparam logic [6:0] NEAR_LIMIT  = 7'd32;
  localparam logic [2:0] NEAR_SPEED  = 3'd5;
  localparam logic [2:0] FAR_GAIN    = 3'd5;
  localparam logic [2:0] FAR_SPEED   = 3'd3;
  localparam logic [9:0] BAD_MAX     = 10'd1023;
  localparam logic [9:0] BAD_FINISH  = 10'd1000;

  typedef struct packed {
    logic [15:0] servo_center;
    logic [7:0]  derivative_gain;
    logic [7:0]  integral_gain;
    logic [7:0]  uncertainty_limit;
    logic [19:0] frames_before_finish;
  } cfg_t;

  // Classified frame handed from front to back (error sum travels beside it).
  typedef struct packed {
    logic signed [7:0] err;
    logic signed [8:0] deriv;
    logic [2:0]        gain;
    logic [2:0]        speed;
    logic              armed;
    logic [9:0]        bad;
  } item_t;

endpackage

@@ src/line_follow_steering_pid_core.sv @@
// Top level of the line-follow steering PID core: config registers, front,
// queue and back. Depends on lfsp_pkg, lfsp_front, lfsp_fifo, lfsp_back.
//
//   channel   dir  handshake                  payload
//   s_axis    in   s_axis_tvalid/tready       one camera frame
//   m_axis    out  m_axis_tvalid/tready       one steering result per frame
//   cfg       in   cfg_valid/cfg_ready        register index and data
//
// One frame per cycle sustained while the output accepts; a result is offered once it
// has passed through the queue, then the product and output registers.
// Reset clears config, queue pointers, controller and valid state at once; no clearing pass.
// The four-entry queue lets input transfers continue while the output stalls;
// input stalls only when the queue fills. cfg_ready_o is always high.
module line_follow_steering_pid_core #(
  parameter int SUM_WIDTH         = 24,
  parameter int FRAME_COUNT_WIDTH = 20
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [6:0] line_position, [14:7] uncertainty, [21:15] far_position,
  // [22] stop_line_seen, [23] zero
  input  logic [23:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [15:0] servo_command, [18:16] speed_target, [19] finish_armed,
  // [29:20] invalid_count, [31:30] zero
  output logic [31:0] m_axis_tdata_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [lfsp_pkg::CFG_INDEX_WIDTH-1:0] cfg_index_i,
  input  logic [lfsp_pkg::CFG_DATA_WIDTH-1:0]  cfg_data_i
);

  localparam int QW = $bits(lfsp_pkg::item_t) + SUM_WIDTH;

  lfsp_pkg::cfg_t         cfg_q;
  lfsp_pkg::item_t        f_item, b_item;
  logic [SUM_WIDTH-1:0]   f_sum, b_sum;
  logic                   push, pop, q_valid, q_full;
  logic [QW-1:0]          q_out;
  logic [15:0]            servo_command;
  logic [2:0]             speed_target;
  logic                   finish_armed;
  logic [9:0]             invalid_count;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = !q_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.servo_center         <= lfsp_pkg::SERVO_CENTER_RST;
      cfg_q.derivative_gain      <= '0;
      cfg_q.integral_gain        <= '0;
      cfg_q.uncertainty_limit    <= lfsp_pkg::UNC_LIMIT_RST;
      cfg_q.frames_before_finish <= lfsp_pkg::FRAMES_RST;
    end else if (cfg_valid_i) begin
      case (lfsp_pkg::reg_e'(cfg_index_i))
        lfsp_pkg::REG_SERVO_CENTER:         cfg_q.servo_center <= cfg_data_i[15:0];
        lfsp_pkg::REG_DERIVATIVE_GAIN:      cfg_q.derivative_gain <= cfg_data_i[7:0];
        lfsp_pkg::REG_INTEGRAL_GAIN:        cfg_q.integral_gain <= cfg_data_i[7:0];
        lfsp_pkg::REG_UNCERTAINTY_LIMIT:    cfg_q.uncertainty_limit <= cfg_data_i[7:0];
        lfsp_pkg::REG_FRAMES_BEFORE_FINISH: cfg_q.frames_before_finish <= cfg_data_i;
        default: ;
      endcase
    end
  end

  lfsp_front #(
    .SUM_WIDTH         (SUM_WIDTH),
    .FRAME_COUNT_WIDTH (FRAME_COUNT_WIDTH)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_q),
    .in_valid_i       (s_axis_tvalid_i),
    .in_ready_i       (s_axis_tready_o),
    .line_position_i  (s_axis_tdata_i[6:0]),
    .uncertainty_i    (s_axis_tdata_i[14:7]),
    .far_position_i   (s_axis_tdata_i[21:15]),
    .stop_line_seen_i (s_axis_tdata_i[22]),
    .push_o           (push),
    .item_o           (f_item),
    .sum_o            (f_sum)
  );

  lfsp_fifo #(
    .WIDTH (QW),
    .DEPTH (4)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  ({f_sum, f_item}),
    .pop_i   (pop),
    .data_o  (q_out),
    .valid_o (q_valid),
    .full_o  (q_full)
  );

  assign b_item = q_out[$bits(lfsp_pkg::item_t)-1:0];
  assign b_sum  = q_out[QW-1:$bits(lfsp_pkg::item_t)];

  lfsp_back #(
    .SUM_WIDTH (SUM_WIDTH)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .fifo_valid_i    (q_valid),
    .item_i          (b_item),
    .sum_i           (b_sum),
    .pop_o           (pop),
    .out_valid_o     (m_axis_tvalid_o),
    .out_ready_i     (m_axis_tready_i),
    .servo_command_o (servo_command),
    .speed_target_o  (speed_target),
    .finish_armed_o  (finish_armed),
    .invalid_count_o (invalid_count)
  );

  assign m_axis_tdata_o = {2'b00, invalid_count, finish_armed, speed_target, servo_command};

endmodule

@@ src/lfsp_fifo.sv @@
// Short register queue between front and back of the steering core.
// Depends on nothing.
module lfsp_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             valid_o,
  output logic             full_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(DEPTH))
    else $error("queue count beyond depth");

endmodule

@@ src/lfsp_front.sv @@
// Front end: takes camera frames, validates position, schedules gain and
// speed, updates PID and frame state. Depends on lfsp_pkg.
module lfsp_front #(
  parameter int SUM_WIDTH         = 24,
  parameter int FRAME_COUNT_WIDTH = 20
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  lfsp_pkg::cfg_t        cfg_i,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  logic [6:0]            line_position_i,
  input  logic [7:0]            uncertainty_i,
  input  logic [6:0]            far_position_i,
  input  logic                  stop_line_seen_i,
  output logic                  push_o,
  output lfsp_pkg::item_t       item_o,
  output logic [SUM_WIDTH-1:0]  sum_o
);

  localparam int S  = SUM_WIDTH;
  localparam int F  = FRAME_COUNT_WIDTH;
  localparam int CW = (F > 20) ? F : 20;

  logic [6:0]          held_q, held_d;
  logic signed [7:0]   perr_q, perr_d;
  logic signed [S-1:0] sum_q, sum_d;
  logic [9:0]          bad_q, bad_d;
  logic [F-1:0]        fc_q, fc_d;

  logic                accept, pos_ok, armed;
  logic [6:0]          far_off, pos;
  logic [2:0]          gain, speed;
  logic [F-1:0]        fc_inc;
  logic signed [7:0]   err;
  logic signed [8:0]   deriv;
  logic signed [S:0]   sum_ext;

  assign accept = in_valid_i && in_ready_i;
  assign push_o = accept;

  always_comb begin
    far_off = (far_position_i >= lfsp_pkg::POS_CENTER) ? far_position_i - lfsp_pkg::POS_CENTER
                                                       : lfsp_pkg::POS_CENTER - far_position_i;
    if (far_off < lfsp_pkg::NEAR_LIMIT) begin
      gain  = 3'd1 + {1'b0, far_off[4:3]};
      speed = lfsp_pkg::NEAR_SPEED - {2'b00, far_off[4]};
    end else begin
      gain  = lfsp_pkg::FAR_GAIN;
      speed = lfsp_pkg::FAR_SPEED;
    end

    fc_inc = (fc_q == {F{1'b1}}) ? fc_q : fc_q + 1'b1;
    fc_d   = fc_inc;

    pos_ok = uncertainty_i < cfg_i.uncertainty_limit;
    if (pos_ok) begin
      pos    = line_position_i;
      held_d = line_position_i;
      bad_d  = '0;
    end else begin
      pos    = held_q;
      held_d = held_q;
      bad_d  = (bad_q < lfsp_pkg::BAD_MAX) ? bad_q + 1'b1 : bad_q;
    end

    if (stop_line_seen_i && (CW'(fc_inc) >= CW'(cfg_i.frames_before_finish))) begin
      bad_d = lfsp_pkg::BAD_FINISH;
      fc_d  = '0;
    end
    armed = CW'(fc_d) >= CW'(cfg_i.frames_before_finish);

    err    = $signed({1'b0, lfsp_pkg::POS_CENTER}) - $signed({1'b0, pos});
    deriv  = $signed({err[7], err}) - $signed({perr_q[7], perr_q});
    perr_d = err;

    sum_ext = $signed({sum_q[S-1], sum_q}) + $signed({{(S - 7){err[7]}}, err});
    if (sum_ext[S] != sum_ext[S-1]) begin
      sum_d = sum_ext[S] ? $signed({1'b1, {(S - 1){1'b0}}}) : $signed({1'b0, {(S - 1){1'b1}}});
    end else begin
      sum_d = sum_ext[S-1:0];
    end
  end

  always_comb begin
    item_o.err   = err;
    item_o.deriv = deriv;
    item_o.gain  = gain;
    item_o.speed = speed;
    item_o.armed = armed;
    item_o.bad   = bad_d;
    sum_o        = sum_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= lfsp_pkg::POS_CENTER;
      perr_q <= '0;
      sum_q  <= '0;
      bad_q  <= '0;
      fc_q   <= '0;
    end else if (accept) begin
      held_q <= held_d;
      perr_q <= perr_d;
      sum_q  <= sum_d;
      bad_q  <= bad_d;
      fc_q   <= fc_d;
    end
  end

endmodule

@@ src/lfsp_back.sv @@
// Back end: multiplies PID terms, sums and saturates the servo command,
// holds the result register. Depends on lfsp_pkg.
module lfsp_back #(
  parameter int SUM_WIDTH = 24
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lfsp_pkg::cfg_t       cfg_i,
  input  logic                 fifo_valid_i,
  input  lfsp_pkg::item_t      item_i,
  input  logic [SUM_WIDTH-1:0] sum_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [15:0]          servo_command_o,
  output logic [2:0]           speed_target_o,
  output logic                 finish_armed_o,
  output logic [9:0]           invalid_count_o
);

  localparam int S    = SUM_WIDTH;
  localparam int CMDW = S + 11;
  localparam logic signed [CMDW-1:0] CMD_MAX = CMDW'(32767);
  localparam logic signed [CMDW-1:0] CMD_MIN = CMDW'(-32768);

  logic                 adv;
  logic                 s1_v_q, out_v_q;
  logic signed [11:0]   pg_q, pg_d;
  logic signed [17:0]   pd_q, pd_d;
  logic signed [S+8:0]  pi_q, pi_d;
  logic [2:0]           s1_speed_q;
  logic                 s1_armed_q;
  logic [9:0]           s1_bad_q;
  logic signed [CMDW-1:0] total;
  logic [15:0]          cmd_d, cmd_q;
  logic [2:0]           speed_q;
  logic                 armed_q;
  logic [9:0]           bad_q;

  assign adv   = !out_v_q || out_ready_i;
  assign pop_o = adv && fifo_valid_i;

  always_comb begin
    pg_d = $signed({1'b0, item_i.gain}) * item_i.err;
    pd_d = $signed({1'b0, cfg_i.derivative_gain}) * item_i.deriv;
    pi_d = $signed({1'b0, cfg_i.integral_gain}) * $signed(sum_i);
  end

  always_comb begin
    total = CMDW'(pi_q) + CMDW'(pd_q) + CMDW'(pg_q)
          + CMDW'($signed({1'b0, cfg_i.servo_center}));
    if (total > CMD_MAX) begin
      cmd_d = 16'h7fff;
    end else if (total < CMD_MIN) begin
      cmd_d = 16'h8000;
    end else begin
      cmd_d = total[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else if (adv) begin
      s1_v_q  <= fifo_valid_i;
      out_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pg_q       <= pg_d;
      pd_q       <= pd_d;
      pi_q       <= pi_d;
      s1_speed_q <= item_i.speed;
      s1_armed_q <= item_i.armed;
      s1_bad_q   <= item_i.bad;
      cmd_q      <= cmd_d;
      speed_q    <= s1_speed_q;
      armed_q    <= s1_armed_q;
      bad_q      <= s1_bad_q;
    end
  end

  assign out_valid_o     = out_v_q;
  assign servo_command_o = cmd_q;
  assign speed_target_o  = speed_q;
  assign finish_armed_o  = armed_q;
  assign invalid_count_o = bad_q;

  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> fifo_valid_i)
    else $error("pop without queued item");

  a_s1_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && s1_v_q) |=> out_v_q)
    else $error("product stage lost an item");

  a_s1_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!adv && s1_v_q) |=> ($stable(s1_v_q) && $stable(pi_q) && $stable(s1_bad_q)))
    else $error("product stage changed under stall");

endmodule

@@ verif/lfsp_steer_checker.sv @@
// Scoreboard for line_follow_steering_pid_core: watches the frame, result and
// register channels, predicts each steering result and compares it field by field.
// Depends on lfsp_pkg.
module lfsp_steer_checker
  import lfsp_pkg::*;
#(
  parameter int SUM_WIDTH         = 24,
  parameter int FRAME_COUNT_WIDTH = 20
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       frame_valid_i,
  input  logic                       frame_ready_i,
  input  logic [23:0]                frame_data_i,
  input  logic                       steer_valid_i,
  input  logic                       steer_ready_i,
  input  logic [31:0]                steer_data_i,
  input  logic                       cfg_valid_i,
  input  logic                       cfg_ready_i,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index_i,
  input  logic [CFG_DATA_WIDTH-1:0]  cfg_data_i,
  output int                         fail_count_o,
  output int                         pending_o
);

  localparam int REPORT_CAP = 100;

  typedef struct packed {
    logic       pad;
    logic       stop;
    logic [6:0] far_pos;
    logic [7:0] unc;
    logic [6:0] pos;
  } frame_t;

  typedef struct packed {
    logic [1:0]         pad;
    logic [9:0]         invalid_count;
    logic               finish_armed;
    logic [2:0]         speed;
    logic signed [15:0] servo;
  } steer_t;

  cfg_t       regs;
  logic [6:0] held_pos;
  int         prev_err;
  longint     err_sum;
  int         bad_frames;
  longint     frame_cnt;
  int         errors = 0;
  steer_t     steer_q[$];

  task automatic report_mismatch(input string msg);
    if (errors < REPORT_CAP) $display("MISMATCH at %0t: %s", $time, msg);
    errors++;
  endtask

  // Advances the controller state by one frame and returns its steering result.
  function automatic steer_t steer_next(input frame_t f);
    longint cnt_max, sum_hi, sum_lo, cmd;
    int     far_off, gain, err, deriv;
    steer_t r;
    cnt_max = (longint'(1) << FRAME_COUNT_WIDTH) - 1;
    sum_hi  = (longint'(1) << (SUM_WIDTH - 1)) - 1;
    sum_lo  = -sum_hi - 1;
    r = '0;

    far_off = int'(f.far_pos) - int'(POS_CENTER);
    if (far_off < 0) far_off = -far_off;
    if (far_off < int'(NEAR_LIMIT)) begin
      gain    = 1 + far_off / 8;
      r.speed = NEAR_SPEED - 3'(far_off / 16);
    end else begin
      gain    = int'(FAR_GAIN);
      r.speed = FAR_SPEED;
    end

    if (frame_cnt < cnt_max) frame_cnt++;
    if (f.unc < regs.uncertainty_limit) begin
      held_pos   = f.pos;
      bad_frames = 0;
    end else if (bad_frames < int'(BAD_MAX)) begin
      bad_frames++;
    end
    // stop line only counts once armed; it restarts the frame counter
    if (f.stop && frame_cnt >= longint'(regs.frames_before_finish)) begin
      bad_frames = int'(BAD_FINISH);
      frame_cnt  = 0;
    end

    err      = int'(POS_CENTER) - int'(held_pos);
    deriv    = err - prev_err;
    prev_err = err;
    err_sum  = err_sum + err;
    if (err_sum > sum_hi) err_sum = sum_hi;
    if (err_sum < sum_lo) err_sum = sum_lo;

    cmd = longint'(regs.servo_center) + gain * err
        + longint'(regs.derivative_gain) * deriv
        + longint'(regs.integral_gain) * err_sum;
    if (cmd > 32767) cmd = 32767;
    if (cmd < -32768) cmd = -32768;

    r.servo         = 16'(cmd);
    r.finish_armed  = frame_cnt >= longint'(regs.frames_before_finish);
    r.invalid_count = 10'(bad_frames);
    return r;
  endfunction

  always @(posedge clk_i) begin
    steer_t got, want;
    if (!rst_ni) begin
      regs.servo_center         = SERVO_CENTER_RST;
      regs.derivative_gain      = '0;
      regs.integral_gain        = '0;
      regs.uncertainty_limit    = UNC_LIMIT_RST;
      regs.frames_before_finish = FRAMES_RST;
      held_pos   = POS_CENTER;
      prev_err   = 0;
      err_sum    = 0;
      bad_frames = 0;
      frame_cnt  = 0;
      steer_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_SERVO_CENTER:         regs.servo_center = cfg_data_i[15:0];
          REG_DERIVATIVE_GAIN:      regs.derivative_gain = cfg_data_i[7:0];
          REG_INTEGRAL_GAIN:        regs.integral_gain = cfg_data_i[7:0];
          REG_UNCERTAINTY_LIMIT:    regs.uncertainty_limit = cfg_data_i[7:0];
          REG_FRAMES_BEFORE_FINISH: regs.frames_before_finish = cfg_data_i[19:0];
          default: ;
        endcase
      end
      if (frame_valid_i && frame_ready_i) steer_q.push_back(steer_next(frame_data_i));
      if (steer_valid_i && steer_ready_i) begin
        got = steer_data_i;
        if (steer_q.size() == 0) begin
          report_mismatch($sformatf("result %h with none expected", steer_data_i));
        end else begin
          want = steer_q.pop_front();
          if (got.servo !== want.servo)
            report_mismatch($sformatf("servo_command %0d, expected %0d", got.servo, want.servo));
          if (got.speed !== want.speed)
            report_mismatch($sformatf("speed_target %0d, expected %0d", got.speed, want.speed));
          if (got.finish_armed !== want.finish_armed)
            report_mismatch($sformatf("finish_armed %b, expected %b",
                                      got.finish_armed, want.finish_armed));
          if (got.invalid_count !== want.invalid_count)
            report_mismatch($sformatf("invalid_count %0d, expected %0d",
                                      got.invalid_count, want.invalid_count));
          if (got.pad !== want.pad)
            report_mismatch($sformatf("padding bits %b not zero", got.pad));
        end
      end
    end
    fail_count_o <= errors;
    pending_o    <= steer_q.size();
  end

endmodule

@@ verif/tb_line_follow_steering_pid_core.sv @@
// Testbench for line_follow_steering_pid_core: directed and random camera frames
// over several register settings, random gaps on both sides and long output stalls.
// Depends on lfsp_pkg, lfsp_steer_checker and the core RTL.
module tb_line_follow_steering_pid_core;
  import lfsp_pkg::*;

  localparam int IDLE_PCT       = 26;
  localparam int PHASES         = 8;
  localparam int PHASE_FRAMES   = 240;
  localparam int HOLD_EVERY     = 700;
  localparam int HOLD_CYCLES    = 400;
  localparam int DRAIN_CYCLES   = 12;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int REG_COUNT      = 5;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_INDEX_LAST = '1;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        s_valid = 1'b0;
  logic        s_ready;
  logic [23:0] s_data = '0;
  logic        m_valid;
  logic        m_ready = 1'b0;
  logic [31:0] m_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
  logic [CFG_DATA_WIDTH-1:0]  cfg_data = '0;

  bit         src_gaps = 1'b1;
  bit         sink_gaps = 1'b1;
  int         fail_count;
  int         pending;
  int         idle_cycles = 0;
  int         stop_pct = 4;
  logic [7:0] unc_limit = UNC_LIMIT_RST;

  line_follow_steering_pid_core u_top (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  lfsp_steer_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .frame_valid_i (s_valid),
    .frame_ready_i (s_ready),
    .frame_data_i  (s_data),
    .steer_valid_i (m_valid),
    .steer_ready_i (m_ready),
    .steer_data_i  (m_data),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_i   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  task automatic send_frame(input logic [6:0] pos, input logic [7:0] unc,
                            input logic [6:0] far_pos, input logic stop);
    while (src_gaps && $urandom_range(0, 99) < IDLE_PCT) begin
      s_valid <= 1'b0;
      @(posedge clk);
    end
    s_valid <= 1'b1;
    s_data  <= {1'b0, stop, far_pos, unc, pos};
    do @(posedge clk); while (!s_ready);
  endtask

  // Uncertainty clusters around the current limit; far position mostly near centre.
  task automatic send_random_frame();
    int         lo, hi;
    logic [7:0] unc;
    logic [6:0] far_pos;
    if ($urandom_range(0, 1) == 1) begin
      lo = (unc_limit < 2) ? 0 : int'(unc_limit) - 2;
      hi = (unc_limit > 253) ? 255 : int'(unc_limit) + 2;
      unc = 8'($urandom_range(lo, hi));
    end else begin
      unc = 8'($urandom_range(0, 255));
    end
    if ($urandom_range(0, 3) == 0) far_pos = 7'($urandom_range(0, 127));
    else far_pos = 7'($urandom_range(24, 104));
    send_frame(7'($urandom_range(0, 127)), unc, far_pos, $urandom_range(0, 99) < stop_pct);
  endtask

  task automatic cfg_write(input logic [CFG_INDEX_WIDTH-1:0] idx,
                           input logic [CFG_DATA_WIDTH-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Narrow registers get junk in the unused upper data bits.
  task automatic write_settings(input cfg_t c);
    logic [CFG_INDEX_WIDTH-1:0] spare;
    spare = CFG_INDEX_WIDTH'($urandom_range(REG_COUNT, int'(REG_INDEX_LAST)));
    cfg_write(REG_SERVO_CENTER, {4'($urandom), c.servo_center});
    cfg_write(REG_DERIVATIVE_GAIN, {12'($urandom), c.derivative_gain});
    cfg_write(REG_INTEGRAL_GAIN, {12'($urandom), c.integral_gain});
    cfg_write(REG_UNCERTAINTY_LIMIT, {12'($urandom), c.uncertainty_limit});
    cfg_write(REG_FRAMES_BEFORE_FINISH, c.frames_before_finish);
    cfg_write(spare, 20'($urandom));
    cfg_valid <= 1'b0;
    unc_limit = c.uncertainty_limit;
  endtask

  task automatic wait_idle();
    s_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Receiver: random back-pressure, plus a long hold-off every HOLD_EVERY transfers.
  initial begin
    int taken;
    taken = 0;
    forever begin
      @(posedge clk);
      if (m_valid && m_ready) begin
        taken++;
        if (taken % HOLD_EVERY == 0) begin
          m_ready <= 1'b0;
          repeat (HOLD_CYCLES) @(posedge clk);
        end
      end
      m_ready <= !sink_gaps || $urandom_range(0, 99) >= IDLE_PCT;
    end
  end

  always @(posedge clk) begin
    if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    cfg_t setting;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset register values: field extremes, validity boundary, gain/speed bands
    send_frame(7'd0,   8'd0,   7'd0,   1'b0);
    send_frame(7'd127, 8'd0,   7'd127, 1'b0);
    send_frame(7'd64,  8'd19,  7'd64,  1'b0);
    send_frame(7'd10,  8'd20,  7'd32,  1'b0);
    send_frame(7'd10,  8'd255, 7'd33,  1'b0);
    send_frame(7'd100, 8'd0,   7'd96,  1'b1);
    send_frame(7'd100, 8'd5,   7'd95,  1'b0);
    send_frame(7'd30,  8'd5,   7'd80,  1'b0);
    send_frame(7'd30,  8'd5,   7'd79,  1'b0);
    send_frame(7'd90,  8'd1,   7'd48,  1'b1);
    send_frame(7'd90,  8'd1,   7'd49,  1'b0);
    send_frame(7'd1,   8'd0,   7'd72,  1'b0);
    send_frame(7'd1,   8'd0,   7'd71,  1'b0);
    send_frame(7'd127, 8'd200, 7'd63,  1'b0);
    wait_idle();

    for (int ph = 0; ph < PHASES; ph++) begin
      setting.servo_center         = 16'($urandom_range(0, 65535));
      setting.derivative_gain      = 8'($urandom_range(0, 12));
      setting.integral_gain        = 8'($urandom_range(0, 2));
      setting.uncertainty_limit    = 8'($urandom_range(0, 255));
      setting.frames_before_finish = 20'($urandom_range(0, 400));
      stop_pct = 4;
      case (ph)
        0: begin
          setting = '0;
          setting.derivative_gain   = '1;
          setting.integral_gain     = '1;
          setting.uncertainty_limit = '1;
        end
        1: begin
          setting.servo_center         = '1;
          setting.derivative_gain      = '0;
          setting.integral_gain        = '0;
          setting.uncertainty_limit    = '0;
          setting.frames_before_finish = '1;
        end
        2: begin
          src_gaps  <= 1'b0;
          sink_gaps <= 1'b0;
        end
        3: begin
          setting.uncertainty_limit    = '0;
          setting.frames_before_finish = 20'($urandom_range(1, 20));
          stop_pct = 2;
        end
        4: begin
          src_gaps  <= 1'b1;
          sink_gaps <= 1'b1;
          setting.derivative_gain = 8'($urandom_range(0, 255));
        end
        default: ;
      endcase
      write_settings(setting);
      repeat (PHASE_FRAMES) send_random_frame();
      wait_idle();
    end

    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
